// ===== rtl/pcgrs_pkg.sv =====
// ----------------------------------------------------------------------------
// pcgrs_pkg
// Shared constants and widths for the PCG32 random source with subset sampling.
// ----------------------------------------------------------------------------
package pcgrs_pkg;

    localparam int DATA_W  = 64;
    localparam int DRAW_W  = 32;
    localparam int KIND_W  = 3;
    localparam int PICK_W  = 7;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_RESTART = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RAW     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BOUNDED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WIDE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SAMPLE  = 3'd4;

    // LCG constants
    localparam logic [63:0] LCG_MULT    = 64'd6364136223846793005;
    localparam logic [63:0] RESET_SEED  = 64'd1234567890;
    localparam logic [63:0] RESET_INC   = {RESET_SEED[62:0], 1'b1};
    localparam logic [63:0] RESET_STATE = (RESET_INC + RESET_SEED) * LCG_MULT + RESET_INC;

endpackage

// ===== rtl/pcg_random_with_k_subset_sampling.sv =====
// ----------------------------------------------------------------------------
// pcg_random_with_k_subset_sampling
// PCG32 XSH-RR source with bounded draws, 64-bit draws and k-of-n sampling.
// ----------------------------------------------------------------------------
// One word in, one word out; the input is not ready while an item is worked.
// A generator step makes three passes through one 32x32 multiplier, and a
// remainder works one bit a cycle. A bounded draw takes one more generator
// step per rejected value. A sample first lists the set bits, then makes
// one bounded draw per pick, then gathers the picks into the mask. Only the
// low MASK_BITS bits of available take part. A finished word waits in the
// output register while the next word can be accepted.
module pcg_random_with_k_subset_sampling
    import pcgrs_pkg::*;
#(
    parameter int MASK_BITS = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [63:0]   cfg_wdata,   // seed
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [103:0]  s_tdata,     // bound[31:0], available[95:32], pick_count[102:96]
    input  logic [2:0]    s_tuser,     // kind
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [63:0]   m_tdata,     // value
    output logic          m_tuser      // refused
);

    localparam int AW = (MASK_BITS > 1) ? $clog2(MASK_BITS) : 1;
    localparam int CW = $clog2(MASK_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RESTART, S_RAW, S_HI, S_LO, S_LIM, S_DRAW, S_MOD, S_SCAN, S_CHK,
        S_SW_RI, S_SW_RJ, S_SW_WI, S_SW_WJ, S_COL_RD, S_COL_OR, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [63:0]            seed_reg;
    logic [MASK_BITS-1:0]   avail_reg;
    logic [PICK_W-1:0]      k_reg;
    logic [DRAW_W-1:0]      bnd_reg;
    logic [DRAW_W-1:0]      limit_reg;
    logic                   sampling_reg;
    logic [AW-1:0]          pos_reg;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          i_reg;
    logic [CW-1:0]          j_reg;
    logic [AW-1:0]          ti_reg;
    logic [63:0]            value_reg;
    logic                   refused_reg;
    logic                   step_reg;
    logic                   restart_reg;
    logic                   rem_start_reg;
    logic [DRAW_W-1:0]      rem_num_reg;
    logic [DRAW_W-1:0]      rem_den_reg;
    logic                   m_valid_reg;
    logic [63:0]            m_data_reg;
    logic                   m_user_reg;

    logic                   gen_done;
    logic [DRAW_W-1:0]      draw;
    logic                   rem_done;
    logic [DRAW_W-1:0]      rem;

    logic [AW-1:0]          list_mem [MASK_BITS];
    logic [AW-1:0]          rd_data_reg;
    logic [AW-1:0]          rd_addr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [AW-1:0]          mem_wdata;
    logic [CW-1:0]          i_inc;
    logic [DRAW_W-1:0]      next_bound;
    logic                   last_pick;
    logic                   accept;

    pcgrs_gen u_gen (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_start    (step_reg),
        .restart_start (restart_reg),
        .seed          (seed_reg),
        .done          (gen_done),
        .draw          (draw)
    );

    pcgrs_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start_reg),
        .dividend (rem_num_reg),
        .divisor  (rem_den_reg),
        .done     (rem_done),
        .rem      (rem)
    );

    assign accept     = s_tvalid && (state_reg == S_IDLE);
    assign s_tready   = (state_reg == S_IDLE);
    assign i_inc      = i_reg + CW'(1);
    assign next_bound = DRAW_W'(count_reg - i_inc);
    assign last_pick  = (8'(i_inc) == 8'(k_reg));

    // Seed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= RESET_SEED;
        end else if (cfg_we) begin
            seed_reg <= cfg_wdata;
        end
    end

    // Position list address and write selection
    always_comb begin
        rd_addr   = i_reg[AW-1:0];
        mem_we    = 1'b0;
        mem_waddr = count_reg[AW-1:0];
        mem_wdata = pos_reg;
        unique case (state_reg)
            S_SCAN:  mem_we = avail_reg[pos_reg];
            S_SW_RJ: rd_addr = j_reg[AW-1:0];
            S_SW_WI: begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[AW-1:0];
                mem_wdata = rd_data_reg;
            end
            S_SW_WJ: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                mem_wdata = ti_reg;
            end
            default: ;
        endcase
    end

    // Position list memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            list_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= list_mem[rd_addr];
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            step_reg      <= 1'b0;
            restart_reg   <= 1'b0;
            rem_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            step_reg      <= 1'b0;
            restart_reg   <= 1'b0;
            rem_start_reg <= 1'b0;
            if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        avail_reg   <= s_tdata[32 +: MASK_BITS];
                        k_reg       <= s_tdata[102:96];
                        value_reg   <= '0;
                        refused_reg <= 1'b0;
                        unique case (s_tuser)
                            KIND_RESTART: begin
                                restart_reg <= 1'b1;
                                state_reg   <= S_RESTART;
                            end
                            KIND_RAW: begin
                                step_reg  <= 1'b1;
                                state_reg <= S_RAW;
                            end
                            KIND_BOUNDED: begin
                                if (s_tdata[31:0] == '0) begin
                                    refused_reg <= 1'b1;
                                    state_reg   <= S_DONE;
                                end else begin
                                    bnd_reg       <= s_tdata[31:0];
                                    sampling_reg  <= 1'b0;
                                    rem_num_reg   <= DRAW_W'(0) - s_tdata[31:0];
                                    rem_den_reg   <= s_tdata[31:0];
                                    rem_start_reg <= 1'b1;
                                    state_reg     <= S_LIM;
                                end
                            end
                            KIND_WIDE: begin
                                step_reg  <= 1'b1;
                                state_reg <= S_HI;
                            end
                            KIND_SAMPLE: begin
                                if (s_tdata[102:96] == '0) begin
                                    refused_reg <= 1'b1;
                                    state_reg   <= S_DONE;
                                end else begin
                                    pos_reg   <= '0;
                                    count_reg <= '0;
                                    state_reg <= S_SCAN;
                                end
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_RESTART: if (gen_done) state_reg <= S_DONE;
                S_RAW: begin
                    if (gen_done) begin
                        value_reg <= {32'd0, draw};
                        state_reg <= S_DONE;
                    end
                end
                S_HI: begin
                    if (gen_done) begin
                        value_reg[63:32] <= draw;
                        step_reg         <= 1'b1;
                        state_reg        <= S_LO;
                    end
                end
                S_LO: begin
                    if (gen_done) begin
                        value_reg[31:0] <= draw;
                        state_reg       <= S_DONE;
                    end
                end
                // Bounded draw (also each sample pick): limit, rejection loop, final remainder
                S_LIM: begin
                    if (rem_done) begin
                        limit_reg <= rem;
                        step_reg  <= 1'b1;
                        state_reg <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    if (gen_done) begin
                        if (draw < limit_reg) begin
                            step_reg <= 1'b1;
                        end else begin
                            rem_num_reg   <= draw;
                            rem_den_reg   <= bnd_reg;
                            rem_start_reg <= 1'b1;
                            state_reg     <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    if (rem_done) begin
                        if (sampling_reg) begin
                            j_reg     <= i_reg + rem[CW-1:0];
                            state_reg <= S_SW_RI;
                        end else begin
                            value_reg <= {32'd0, rem};
                            state_reg <= S_DONE;
                        end
                    end
                end
                // List the set mask bits in ascending order
                S_SCAN: begin
                    if (avail_reg[pos_reg]) begin
                        count_reg <= count_reg + CW'(1);
                    end
                    pos_reg <= pos_reg + AW'(1);
                    if (pos_reg == AW'(MASK_BITS - 1)) begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (8'(count_reg) < 8'(k_reg)) begin
                        refused_reg <= 1'b1;
                        state_reg   <= S_DONE;
                    end else begin
                        i_reg         <= '0;
                        sampling_reg  <= 1'b1;
                        bnd_reg       <= DRAW_W'(count_reg);
                        rem_num_reg   <= DRAW_W'(0) - DRAW_W'(count_reg);
                        rem_den_reg   <= DRAW_W'(count_reg);
                        rem_start_reg <= 1'b1;
                        state_reg     <= S_LIM;
                    end
                end
                // Swap list slots i and j
                S_SW_RI: state_reg <= S_SW_RJ;
                S_SW_RJ: begin
                    ti_reg    <= rd_data_reg;
                    state_reg <= S_SW_WI;
                end
                S_SW_WI: state_reg <= S_SW_WJ;
                S_SW_WJ: begin
                    if (last_pick) begin
                        i_reg     <= '0;
                        state_reg <= S_COL_RD;
                    end else begin
                        i_reg         <= i_inc;
                        bnd_reg       <= next_bound;
                        rem_num_reg   <= DRAW_W'(0) - next_bound;
                        rem_den_reg   <= next_bound;
                        rem_start_reg <= 1'b1;
                        state_reg     <= S_LIM;
                    end
                end
                // Gather the chosen positions into a mask
                S_COL_RD: state_reg <= S_COL_OR;
                S_COL_OR: begin
                    value_reg <= value_reg | (64'd1 << rd_data_reg);
                    i_reg     <= i_inc;
                    state_reg <= last_pick ? S_DONE : S_COL_RD;
                end
                S_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= value_reg;
                        m_user_reg  <= refused_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ===== rtl/pcgrs_gen.sv =====
// ----------------------------------------------------------------------------
// pcgrs_gen
// LCG state and XSH-RR output; one step takes three passes through a shared
// 32x32 multiplier.
// ----------------------------------------------------------------------------
module pcgrs_gen
    import pcgrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_start,
    input  logic              restart_start,
    input  logic [63:0]       seed,
    output logic              done,
    output logic [DRAW_W-1:0] draw
);

    typedef enum logic [1:0] {G_IDLE, G_MUL0, G_MUL1, G_MUL2} gphase_t;

    gphase_t            phase_reg;
    logic [63:0]        state_reg;
    logic [63:0]        inc_reg;
    logic [63:0]        acc_reg;
    logic [31:0]        cross_reg;
    logic [DRAW_W-1:0]  draw_reg;
    logic               done_reg;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        prod;
    logic [63:0]        inc_next;

    // XSH-RR output permutation of the current state
    function automatic logic [31:0] xsh_rr(input logic [63:0] old);
        logic [31:0] mixed;
        logic [4:0]  rot;
        mixed = 32'(((old >> 18) ^ old) >> 27);
        rot   = old[63:59];
        return (mixed >> rot) | (mixed << (6'd32 - {1'b0, rot}));
    endfunction

    // Select multiplier operands by phase
    always_comb begin
        mul_a = state_reg[31:0];
        mul_b = LCG_MULT[31:0];
        if (phase_reg == G_MUL1) begin
            mul_a = state_reg[63:32];
        end else if (phase_reg == G_MUL2) begin
            mul_b = LCG_MULT[63:32];
        end
    end

    assign prod     = mul_a * mul_b;
    assign inc_next = {seed[62:0], 1'b1};

    // Sequence the three partial products and fold them into the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= G_IDLE;
            state_reg <= RESET_STATE;
            inc_reg   <= RESET_INC;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (phase_reg)
                G_IDLE: begin
                    if (restart_start) begin
                        inc_reg   <= inc_next;
                        state_reg <= inc_next + seed;
                        phase_reg <= G_MUL0;
                    end else if (step_start) begin
                        draw_reg  <= xsh_rr(state_reg);
                        phase_reg <= G_MUL0;
                    end
                end
                G_MUL0: begin
                    acc_reg   <= prod;
                    phase_reg <= G_MUL1;
                end
                G_MUL1: begin
                    cross_reg <= prod[31:0];
                    phase_reg <= G_MUL2;
                end
                G_MUL2: begin
                    state_reg <= acc_reg + {cross_reg + prod[31:0], 32'd0} + inc_reg;
                    done_reg  <= 1'b1;
                    phase_reg <= G_IDLE;
                end
                default: phase_reg <= G_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign draw = draw_reg;

endmodule

// ===== rtl/pcgrs_rem.sv =====
// ----------------------------------------------------------------------------
// pcgrs_rem
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module pcgrs_rem
    import pcgrs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DRAW_W-1:0] dividend,
    input  logic [DRAW_W-1:0] divisor,
    output logic              done,
    output logic [DRAW_W-1:0] rem
);

    logic              busy_reg;
    logic              done_reg;
    logic [4:0]        cnt_reg;
    logic [DRAW_W-1:0] num_reg;
    logic [DRAW_W-1:0] den_reg;
    logic [DRAW_W-1:0] rem_reg;
    logic [DRAW_W:0]   trial;
    logic [DRAW_W-1:0] rem_next;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
        trial    = {rem_reg, num_reg[DRAW_W-1]};
        rem_next = trial[DRAW_W-1:0];
        if (trial >= {1'b0, den_reg}) begin
            rem_next = DRAW_W'(trial - {1'b0, den_reg});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
                num_reg  <= dividend;
                den_reg  <= divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[DRAW_W-2:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
